/* src/oaief_pkg.sv */
// ----------------------------------------------------------------------------
// oaief_pkg
// Shared types and constants for the ordered element array block.
// ----------------------------------------------------------------------------
package oaief_pkg;

  // Default sizing
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CMD_W    = 4;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int SIZE_W   = 7;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK     = 4'd0,
    CMD_PUSH_FRONT    = 4'd1,
    CMD_INSERT_AT     = 4'd2,
    CMD_POP_BACK      = 4'd3,
    CMD_POP_FRONT     = 4'd4,
    CMD_ERASE_COUNT   = 4'd5,
    CMD_ERASE_BETWEEN = 4'd6,
    CMD_FIND          = 4'd7,
    CMD_READ          = 4'd8,
    CMD_WRITE         = 4'd9
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SETUP,
    ST_SHIFT,
    ST_FINAL,
    ST_SEARCH,
    ST_FETCH,
    ST_RESP
  } state_t;

endpackage

/* src/oaief_ram.sv */
// ----------------------------------------------------------------------------
// oaief_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module oaief_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/ordered_array_insert_erase_find.sv */
// ----------------------------------------------------------------------------
// ordered_array_insert_erase_find
// Fixed-capacity ordered element array: push/pop at both ends, insert, erase,
// find, read and write, sequenced over one RAM port pair.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------
//  in      | command, position, extent, value          | in_valid / in_ready
//  out     | status, found_index, read_value, size_now | out_valid / out_ready
//
//  The single RAM read/write port pair moves or compares one element per
//  cycle.
//  Reset clears the element count and control state; storage is not cleared.
//  in_ready is high only in idle; a result waiting on out_ready does not block
//  the next transaction until its own result is due.
// ----------------------------------------------------------------------------
module ordered_array_insert_erase_find
  import oaief_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       command,
  input  logic [POS_W-1:0]       position,
  input  logic [POS_W-1:0]       extent,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [FOUND_W-1:0]     found_index,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [SIZE_W-1:0]      size_now
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Control registers
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          out_valid_r, out_valid_next;
  logic          pend, pend_next;

  // Transaction and work registers
  cmd_t                   cmd_q;
  logic [POS_W-1:0]       pos_q, ext_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IW-1:0]          rp, rp_next;
  logic [IW-1:0]          wa, wa_next;
  logic [IW-1:0]          ca, ca_next;
  logic [IW-1:0]          base, base_next;
  logic [IW-1:0]          start, start_next;
  logic [CW-1:0]          stop, stop_next;
  logic [CW-1:0]          shift, shift_next;
  logic [CW-1:0]          left, left_next;
  logic                   grow, grow_next;
  logic                   up, up_next;
  status_t                st_w, st_next;
  logic [IW-1:0]          found_w, found_next;
  logic [VALUE_WIDTH-1:0] rdv_w, rdv_next;

  // Result registers
  status_t                o_status, o_status_next;
  logic [FOUND_W-1:0]     o_found, o_found_next;
  logic [VALUE_WIDTH-1:0] o_rdv, o_rdv_next;
  logic [SIZE_W-1:0]      o_size, o_size_next;

  // RAM ports
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  // Widened operands
  logic [EW-1:0] n_ext, p_ext, e_ext, sum_ext, ins_ext, stop_ext, found_ext;
  logic          p_lt_n;
  logic [IW-1:0] p_idx;

  oaief_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Bounds and clamped positions
  assign n_ext     = EW'(count);
  assign p_ext     = EW'(pos_q);
  assign e_ext     = EW'(ext_q);
  assign sum_ext   = p_ext + e_ext;
  assign p_lt_n    = (p_ext < n_ext);
  assign p_idx     = p_ext[IW-1:0];
  assign found_ext = EW'(found_w);

  assign ins_ext = (cmd_q == CMD_PUSH_BACK)  ? n_ext :
                   (cmd_q == CMD_PUSH_FRONT) ? '0    :
                   (p_lt_n ? p_ext : n_ext);

  assign stop_ext = (cmd_q == CMD_ERASE_COUNT) ?
                    ((sum_ext < n_ext) ? sum_ext : n_ext) :
                    ((e_ext < n_ext) ? e_ext : n_ext);

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign status      = o_status;
  assign found_index = o_found;
  assign read_value  = o_rdv;
  assign size_now    = o_size;

  // Sequencer: next state, work registers and RAM control
  always_comb begin
    state_next     = state;
    count_next     = count;
    out_valid_next = out_valid_r;
    pend_next      = pend;
    rp_next        = rp;
    wa_next        = wa;
    ca_next        = ca;
    base_next      = base;
    start_next     = start;
    stop_next      = stop;
    shift_next     = shift;
    left_next      = left;
    grow_next      = grow;
    up_next        = up;
    st_next        = st_w;
    found_next     = found_w;
    rdv_next       = rdv_w;
    o_status_next  = o_status;
    o_found_next   = o_found;
    o_rdv_next     = o_rdv;
    o_size_next    = o_size;
    mem_we         = 1'b0;
    mem_waddr      = wa;
    mem_wdata      = mem_rdata;
    mem_raddr      = rp;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          st_next    = STAT_OK;
          found_next = '0;
          rdv_next   = '0;
          pend_next  = 1'b0;
          state_next = ST_PLAN;
        end
      end

      ST_PLAN: begin
        state_next = ST_RESP;
        unique case (cmd_q) inside
          CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
            if (count == CAP_C) begin
              st_next = STAT_FULL;
            end else begin
              base_next  = ins_ext[IW-1:0];
              left_next  = CW'(n_ext - ins_ext);
              rp_next    = IW'(count - CW'(1));
              grow_next  = 1'b1;
              up_next    = 1'b1;
              state_next = ST_SHIFT;
            end
          end
          CMD_POP_BACK: begin
            if (count == '0) begin
              st_next = STAT_EMPTY;
            end else begin
              count_next = count - CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (count == '0) begin
              st_next = STAT_EMPTY;
            end else begin
              start_next = '0;
              stop_next  = CW'(1);
              grow_next  = 1'b0;
              state_next = ST_SETUP;
            end
          end
          CMD_ERASE_COUNT: begin
            if (p_lt_n) begin
              start_next = p_idx;
              stop_next  = stop_ext[CW-1:0];
              grow_next  = 1'b0;
              state_next = ST_SETUP;
            end
          end
          CMD_ERASE_BETWEEN: begin
            if (p_lt_n && (p_ext < e_ext)) begin
              start_next = p_idx;
              stop_next  = stop_ext[CW-1:0];
              grow_next  = 1'b0;
              state_next = ST_SETUP;
            end
          end
          CMD_FIND: begin
            if (count == '0) begin
              st_next = STAT_NOTFOUND;
            end else begin
              rp_next    = '0;
              left_next  = count;
              state_next = ST_SEARCH;
            end
          end
          CMD_READ: begin
            if (p_lt_n) begin
              mem_raddr  = p_idx;
              state_next = ST_FETCH;
            end else begin
              st_next = STAT_NOTFOUND;
            end
          end
          CMD_WRITE: begin
            if (p_lt_n) begin
              mem_we    = 1'b1;
              mem_waddr = p_idx;
              mem_wdata = val_q;
            end else begin
              st_next = STAT_NOTFOUND;
            end
          end
          default: begin
            st_next = STAT_NOTFOUND;
          end
        endcase
      end

      // Prepare the downward move that closes an erase gap
      ST_SETUP: begin
        shift_next = stop - CW'(start);
        left_next  = count - stop;
        rp_next    = stop[IW-1:0];
        up_next    = 1'b0;
        state_next = ST_SHIFT;
      end

      // Read one element, write the previous one to its new place
      ST_SHIFT: begin
        mem_we = pend;
        if (left != '0) begin
          pend_next = 1'b1;
          wa_next   = up ? (rp + IW'(1)) : (rp - shift[IW-1:0]);
          rp_next   = up ? (rp - IW'(1)) : (rp + IW'(1));
          left_next = left - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = ST_FINAL;
          end
        end
      end

      // Place the new element or shrink the count
      ST_FINAL: begin
        if (grow) begin
          mem_we     = 1'b1;
          mem_waddr  = base;
          mem_wdata  = val_q;
          count_next = count + CW'(1);
        end else begin
          count_next = count - shift;
        end
        state_next = ST_RESP;
      end

      // Compare the element fetched last cycle, fetch the next one
      ST_SEARCH: begin
        if (pend && (mem_rdata == val_q)) begin
          found_next = ca;
          state_next = ST_RESP;
        end else if (left != '0) begin
          pend_next = 1'b1;
          ca_next   = rp;
          rp_next   = rp + IW'(1);
          left_next = left - CW'(1);
        end else begin
          st_next    = STAT_NOTFOUND;
          state_next = ST_RESP;
        end
      end

      ST_FETCH: begin
        rdv_next   = mem_rdata;
        state_next = ST_RESP;
      end

      // Hand over the result once the output register is free
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          o_status_next  = st_w;
          o_found_next   = found_ext[FOUND_W-1:0];
          o_rdv_next     = rdv_w;
          o_size_next    = n_ext[SIZE_W-1:0];
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      out_valid_r <= 1'b0;
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      out_valid_r <= out_valid_next;
      pend        <= pend_next;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= cmd_t'(command);
      pos_q <= position;
      ext_q <= extent;
      val_q <= value;
    end
  end

  // Work and result registers
  always_ff @(posedge clk) begin
    rp       <= rp_next;
    wa       <= wa_next;
    ca       <= ca_next;
    base     <= base_next;
    start    <= start_next;
    stop     <= stop_next;
    shift    <= shift_next;
    left     <= left_next;
    grow     <= grow_next;
    up       <= up_next;
    st_w     <= st_next;
    found_w  <= found_next;
    rdv_w    <= rdv_next;
    o_status <= o_status_next;
    o_found  <= o_found_next;
    o_rdv    <= o_rdv_next;
    o_size   <= o_size_next;
  end

endmodule
